### src/fts_pkg.sv
// shared types and constants for the file type sniffer
package fts_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_END   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REGULAR = 2'd0,
    KIND_DIR     = 2'd1,
    KIND_CHAR    = 2'd2,
    KIND_BLOCK   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    CLS_DIR     = 4'd0,
    CLS_CHR     = 4'd1,
    CLS_BLK     = 4'd2,
    CLS_ARCHIVE = 4'd3,
    CLS_EXEC    = 4'd4,
    CLS_SCRIPT  = 4'd5,
    CLS_C       = 4'd6,
    CLS_ENGLISH = 4'd7,
    CLS_ASCII   = 4'd8,
    CLS_DATA    = 4'd9
  } class_t;

  typedef enum logic [2:0] {
    REG_ARCHIVE_MAGIC = 3'd0,
    REG_EXEC_MAGIC    = 3'd1,
    REG_SPLIT_MARKER  = 3'd2,
    REG_CODE_PCT      = 3'd3,
    REG_ENGLISH_PCT   = 3'd4
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PCT_W  = 7;

  localparam logic [15:0]      ARCHIVE_MAGIC_RST = 16'hFF65;  // 0177545
  localparam logic [15:0]      EXEC_MAGIC_RST    = 16'h0301;  // 001401
  localparam logic [15:0]      SPLIT_MARKER_RST  = 16'h0420;  // 002040
  localparam logic [PCT_W-1:0] CODE_PCT_RST      = 7'd1;
  localparam logic [PCT_W-1:0] ENGLISH_PCT_RST   = 7'd25;
  localparam logic [PCT_W-1:0] PCT_SCALE         = 7'd100;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] file_kind;
    logic       exec_any;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] file_class;
    logic       split_space;
    logic       not_stripped;
  } out_item_t;

  typedef struct packed {
    logic [15:0]      archive_magic;
    logic [15:0]      exec_magic;
    logic [15:0]      split_marker;
    logic [PCT_W-1:0] code_pct_limit;
    logic [PCT_W-1:0] english_pct_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        exec_held;
    logic [31:0] header_words;
    logic        symbols_seen;
    logic        high_bit_seen;
  } flags_t;

endpackage

### src/fts_cfg_regs.sv
// configuration register file behind the bus port
module fts_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fts_pkg::ADDR_W-1:0] paddr,
  input  logic [fts_pkg::DATA_W-1:0] pwdata,
  output logic [fts_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output fts_pkg::cfg_t              cfg
);

  fts_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[fts_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.archive_magic     <= fts_pkg::ARCHIVE_MAGIC_RST;
      cfg_r.exec_magic        <= fts_pkg::EXEC_MAGIC_RST;
      cfg_r.split_marker      <= fts_pkg::SPLIT_MARKER_RST;
      cfg_r.code_pct_limit    <= fts_pkg::CODE_PCT_RST;
      cfg_r.english_pct_limit <= fts_pkg::ENGLISH_PCT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        fts_pkg::REG_ARCHIVE_MAGIC: cfg_r.archive_magic     <= pwdata[15:0];
        fts_pkg::REG_EXEC_MAGIC:    cfg_r.exec_magic        <= pwdata[15:0];
        fts_pkg::REG_SPLIT_MARKER:  cfg_r.split_marker      <= pwdata[15:0];
        fts_pkg::REG_CODE_PCT:      cfg_r.code_pct_limit    <= pwdata[fts_pkg::PCT_W-1:0];
        fts_pkg::REG_ENGLISH_PCT:   cfg_r.english_pct_limit <= pwdata[fts_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fts_pkg::REG_ARCHIVE_MAGIC: prdata = {16'd0, cfg_r.archive_magic};
      fts_pkg::REG_EXEC_MAGIC:    prdata = {16'd0, cfg_r.exec_magic};
      fts_pkg::REG_SPLIT_MARKER:  prdata = {16'd0, cfg_r.split_marker};
      fts_pkg::REG_CODE_PCT:      prdata = {25'd0, cfg_r.code_pct_limit};
      fts_pkg::REG_ENGLISH_PCT:   prdata = {25'd0, cfg_r.english_pct_limit};
      default:                    prdata = '0;
    endcase
  end

endmodule

### src/fts_stats.sv
// per-file state: attributes, header latches and content counters
module fts_stats #(
  parameter int unsigned BLOCK_BYTES = 1024,
  parameter int unsigned CW = $clog2(BLOCK_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  fts_pkg::in_item_t item,
  output fts_pkg::flags_t  flags,
  output logic [CW-1:0]    byte_count,
  output logic [CW-1:0]    punct_count,
  output logic [CW-1:0]    letter_count
);

  localparam logic [CW-1:0] LIMIT = CW'(BLOCK_BYTES);

  fts_pkg::flags_t flags_r, flags_nxt;
  logic [CW-1:0]   byte_count_r, byte_count_nxt;
  logic [CW-1:0]   punct_count_r, punct_count_nxt;
  logic [CW-1:0]   letter_count_r, letter_count_nxt;

  function automatic logic is_punct(input logic [7:0] b);
    case (b) inside
      8'h3B, 8'h7B, 8'h7D, 8'h23, 8'h2A, 8'h3C, 8'h3E, 8'h2F: is_punct = 1'b1;
      default: is_punct = 1'b0;
    endcase
  endfunction

  function automatic logic is_common_letter(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b >= 8'h41 && b <= 8'h5A) c = b | 8'h20;
    case (c) inside
      8'h65, 8'h74, 8'h61, 8'h6F, 8'h69, 8'h6E, 8'h73: is_common_letter = 1'b1;
      default: is_common_letter = 1'b0;
    endcase
  endfunction

  always_comb begin
    flags_nxt        = flags_r;
    byte_count_nxt   = byte_count_r;
    punct_count_nxt  = punct_count_r;
    letter_count_nxt = letter_count_r;
    if (step) begin
      case (item.mode)
        fts_pkg::MODE_START: begin
          flags_nxt.kind          = item.file_kind;
          flags_nxt.exec_held     = item.exec_any;
          flags_nxt.header_words  = '0;
          flags_nxt.symbols_seen  = 1'b0;
          flags_nxt.high_bit_seen = 1'b0;
          byte_count_nxt          = '0;
          punct_count_nxt         = '0;
          letter_count_nxt        = '0;
        end
        fts_pkg::MODE_BYTE: begin
          // bytes past the block are dropped
          if (byte_count_r < LIMIT) begin
            if (byte_count_r < CW'(4))
              flags_nxt.header_words[8*byte_count_r[1:0] +: 8] = item.data_byte;
            // symbol bytes 28 to 31
            if (byte_count_r[CW-1:2] == (CW-2)'(7) && item.data_byte != 8'd0)
              flags_nxt.symbols_seen = 1'b1;
            if (item.data_byte[7])
              flags_nxt.high_bit_seen = 1'b1;
            if (is_punct(item.data_byte))
              punct_count_nxt = punct_count_r + CW'(1);
            if (is_common_letter(item.data_byte))
              letter_count_nxt = letter_count_r + CW'(1);
            byte_count_nxt = byte_count_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r        <= '0;
      byte_count_r   <= '0;
      punct_count_r  <= '0;
      letter_count_r <= '0;
    end else begin
      flags_r        <= flags_nxt;
      byte_count_r   <= byte_count_nxt;
      punct_count_r  <= punct_count_nxt;
      letter_count_r <= letter_count_nxt;
    end
  end

  assign flags        = flags_r;
  assign byte_count   = byte_count_r;
  assign punct_count  = punct_count_r;
  assign letter_count = letter_count_r;

endmodule

### src/fts_classify.sv
// classification of the held state into the result register
module fts_classify #(
  parameter int unsigned BLOCK_BYTES = 1024,
  parameter int unsigned CW = $clog2(BLOCK_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  fts_pkg::cfg_t      cfg,
  input  fts_pkg::flags_t    flags,
  input  logic [CW-1:0]      byte_count,
  input  logic [CW-1:0]      punct_count,
  input  logic [CW-1:0]      letter_count,
  input  logic               out_stall,
  output logic               out_valid,
  output fts_pkg::out_item_t out_data
);

  localparam int unsigned PW = CW + fts_pkg::PCT_W + 1;

  logic               out_valid_r;
  fts_pkg::out_item_t out_data_r, out_data_nxt;
  logic [15:0]        first_word, second_word;
  logic [PW-1:0]      total_code, total_english, punct_scaled, letter_scaled;
  logic               code_above, english_above;

  assign first_word  = flags.header_words[15:0];
  assign second_word = flags.header_words[31:16];

  // floor(100 * n / total) > limit  <=>  100 * n >= (limit + 1) * total
  assign punct_scaled  = PW'(punct_count) * PW'(fts_pkg::PCT_SCALE);
  assign letter_scaled = PW'(letter_count) * PW'(fts_pkg::PCT_SCALE);
  assign total_code    = (PW'(cfg.code_pct_limit) + PW'(1)) * PW'(byte_count);
  assign total_english = (PW'(cfg.english_pct_limit) + PW'(1)) * PW'(byte_count);
  assign code_above    = punct_scaled >= total_code;
  assign english_above = letter_scaled >= total_english;

  always_comb begin
    out_data_nxt = '0;
    if (flags.kind == fts_pkg::KIND_DIR)
      out_data_nxt.file_class = fts_pkg::CLS_DIR;
    else if (flags.kind == fts_pkg::KIND_CHAR)
      out_data_nxt.file_class = fts_pkg::CLS_CHR;
    else if (flags.kind == fts_pkg::KIND_BLOCK)
      out_data_nxt.file_class = fts_pkg::CLS_BLK;
    else if (first_word == cfg.archive_magic)
      out_data_nxt.file_class = fts_pkg::CLS_ARCHIVE;
    else if (first_word == cfg.exec_magic) begin
      out_data_nxt.file_class   = fts_pkg::CLS_EXEC;
      out_data_nxt.split_space  = second_word == cfg.split_marker;
      out_data_nxt.not_stripped = flags.symbols_seen;
    end else if (flags.exec_held)
      out_data_nxt.file_class = fts_pkg::CLS_SCRIPT;
    else if (flags.high_bit_seen)
      out_data_nxt.file_class = fts_pkg::CLS_DATA;
    else if (byte_count == '0)
      out_data_nxt.file_class = fts_pkg::CLS_ASCII;
    else if (code_above)
      out_data_nxt.file_class = fts_pkg::CLS_C;
    else if (english_above)
      out_data_nxt.file_class = fts_pkg::CLS_ENGLISH;
    else
      out_data_nxt.file_class = fts_pkg::CLS_ASCII;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/file_type_sniffer.sv
// file type sniffer top level: input register, state, classification, bus port
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid, in_stall  | in_data (mode, file_kind, exec_any, data_byte)
//  out_    | result    | out_valid, out_stall| out_data (file_class, split_space, not_stripped)
//  config  | bus write | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// one request per cycle while in_stall is low; a request waits in the input register and updates
// the counters from there, so an end request's result is loaded as it leaves that register.
// synchronous reset loads register defaults and clears all file state.
// out_stall holds the result register; only an end request waiting behind it raises in_stall.
module file_type_sniffer #(
  parameter int unsigned BLOCK_BYTES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fts_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fts_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fts_pkg::ADDR_W-1:0] paddr,
  input  logic [fts_pkg::DATA_W-1:0] pwdata,
  output logic [fts_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);

  logic              req_valid_r;
  fts_pkg::in_item_t req_r;
  logic              req_go, req_end, out_free;
  fts_pkg::cfg_t     cfg;
  fts_pkg::flags_t   flags;
  logic [CW-1:0]     byte_count, punct_count, letter_count;

  assign req_end  = req_r.mode == fts_pkg::MODE_END;
  assign out_free = !out_valid || !out_stall;
  assign req_go   = req_valid_r && (!req_end || out_free);
  assign in_stall = req_valid_r && !req_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_data;
    end
  end

  fts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fts_stats #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CW          (CW)
  ) u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (req_go),
    .item         (req_r),
    .flags        (flags),
    .byte_count   (byte_count),
    .punct_count  (punct_count),
    .letter_count (letter_count)
  );

  fts_classify #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CW          (CW)
  ) u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (req_go && req_end),
    .cfg          (cfg),
    .flags        (flags),
    .byte_count   (byte_count),
    .punct_count  (punct_count),
    .letter_count (letter_count),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

### test/tb_top.sv
// testbench for the file type sniffer: random file streams checked against a local classifier
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLOCK_LEN = 1024;
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int PHASE_REQUESTS = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fts_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fts_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fts_pkg::ADDR_W-1:0] paddr = '0;
  logic [fts_pkg::DATA_W-1:0] pwdata = '0;
  logic [fts_pkg::DATA_W-1:0] prdata;
  logic pready;

  file_type_sniffer #(.BLOCK_BYTES(BLOCK_LEN)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fts_pkg::in_item_t  pending_requests[$];
  fts_pkg::out_item_t classes_due[$];
  int                 fail_count = 0;
  int                 phase_items = 0;

  // local copy of the registers and the per-file state
  fts_pkg::cfg_t  cfg_shadow;
  fts_pkg::kind_t kind_q = fts_pkg::KIND_REGULAR;
  logic           exec_q = 1'b0;
  int unsigned    byte_cnt = 0;
  logic [31:0]    hdr = '0;
  logic           sym_seen = 1'b0;
  logic           hi_seen = 1'b0;
  int unsigned    punct_cnt = 0;
  int unsigned    letter_cnt = 0;

  function automatic bit pct_above(int unsigned cnt, int unsigned total,
                                   logic [fts_pkg::PCT_W-1:0] limit);
    return longint'(cnt) * 100 >= (longint'(limit) + 1) * longint'(total);
  endfunction

  function automatic fts_pkg::out_item_t classify_file();
    fts_pkg::out_item_t res;
    res = '0;
    if (kind_q == fts_pkg::KIND_DIR) res.file_class = fts_pkg::CLS_DIR;
    else if (kind_q == fts_pkg::KIND_CHAR) res.file_class = fts_pkg::CLS_CHR;
    else if (kind_q == fts_pkg::KIND_BLOCK) res.file_class = fts_pkg::CLS_BLK;
    else if (hdr[15:0] == cfg_shadow.archive_magic) res.file_class = fts_pkg::CLS_ARCHIVE;
    else if (hdr[15:0] == cfg_shadow.exec_magic) begin
      res.file_class   = fts_pkg::CLS_EXEC;
      res.split_space  = (hdr[31:16] == cfg_shadow.split_marker);
      res.not_stripped = sym_seen;
    end else if (exec_q) res.file_class = fts_pkg::CLS_SCRIPT;
    else if (hi_seen) res.file_class = fts_pkg::CLS_DATA;
    else if (byte_cnt == 0) res.file_class = fts_pkg::CLS_ASCII;
    else if (pct_above(punct_cnt, byte_cnt, cfg_shadow.code_pct_limit))
      res.file_class = fts_pkg::CLS_C;
    else if (pct_above(letter_cnt, byte_cnt, cfg_shadow.english_pct_limit))
      res.file_class = fts_pkg::CLS_ENGLISH;
    else res.file_class = fts_pkg::CLS_ASCII;
    return res;
  endfunction

  task automatic sniff_request(fts_pkg::in_item_t r);
    logic [7:0] folded;
    case (r.mode)
      fts_pkg::MODE_START: begin
        kind_q     = fts_pkg::kind_t'(r.file_kind);
        exec_q     = r.exec_any;
        byte_cnt   = 0;
        hdr        = '0;
        sym_seen   = 1'b0;
        hi_seen    = 1'b0;
        punct_cnt  = 0;
        letter_cnt = 0;
      end
      fts_pkg::MODE_BYTE: begin
        // bytes past the block size change nothing
        if (byte_cnt < BLOCK_LEN) begin
          if (byte_cnt < 4) hdr[8*byte_cnt +: 8] = r.data_byte;
          if (byte_cnt >= 28 && byte_cnt <= 31 && r.data_byte != 8'h00) sym_seen = 1'b1;
          if (r.data_byte[7]) hi_seen = 1'b1;
          if (r.data_byte inside {";", "{", "}", "#", "*", "<", ">", "/"})
            punct_cnt++;
          folded = r.data_byte;
          if (folded >= "A" && folded <= "Z") folded = folded + 8'h20;
          if (folded inside {"e", "t", "a", "o", "i", "n", "s"}) letter_cnt++;
          byte_cnt++;
        end
      end
      fts_pkg::MODE_END: classes_due.push_back(classify_file());
      default: ;
    endcase
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // request driver
  int req_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      req_gap  <= 0;
    end else if (!in_valid || !in_stall) begin
      if (req_gap != 0) begin
        in_valid <= 1'b0;
        req_gap  <= req_gap - 1;
      end else if (pending_requests.size() != 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        req_gap  <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= idle_len();
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    fts_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) sniff_request(in_data);
      if (out_valid && !out_stall) begin
        if (classes_due.size() == 0) begin
          $error("unexpected result: file_class %0d", out_data.file_class);
          fail_count++;
        end else begin
          want = classes_due.pop_front();
          if (out_data.file_class !== want.file_class) begin
            $error("file_class expected %0d got %0d", want.file_class, out_data.file_class);
            fail_count++;
          end
          if (out_data.split_space !== want.split_space) begin
            $error("split_space expected %0d got %0d", want.split_space, out_data.split_space);
            fail_count++;
          end
          if (out_data.not_stripped !== want.not_stripped) begin
            $error("not_stripped expected %0d got %0d", want.not_stripped,
                   out_data.not_stripped);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(fts_pkg::reg_idx_t idx, logic [fts_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fts_pkg::REG_ARCHIVE_MAGIC: cfg_shadow.archive_magic = value[15:0];
      fts_pkg::REG_EXEC_MAGIC:    cfg_shadow.exec_magic = value[15:0];
      fts_pkg::REG_SPLIT_MARKER:  cfg_shadow.split_marker = value[15:0];
      fts_pkg::REG_CODE_PCT:      cfg_shadow.code_pct_limit = value[fts_pkg::PCT_W-1:0];
      fts_pkg::REG_ENGLISH_PCT:   cfg_shadow.english_pct_limit = value[fts_pkg::PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_request(logic [1:0] mode, logic [1:0] kind, logic ex, logic [7:0] b);
    fts_pkg::in_item_t r;
    r.mode      = mode;
    r.file_kind = kind;
    r.exec_any  = ex;
    r.data_byte = b;
    pending_requests.push_back(r);
    if (mode != MODE_IGNORED) phase_items++;
  endtask

  task automatic queue_byte(logic [7:0] b);
    queue_request(fts_pkg::MODE_BYTE, 2'($urandom), 1'($urandom), b);
  endtask

  function automatic logic [7:0] text_byte(int punct_w, int letter_w, int high_w);
    string punct_set;
    string letter_set;
    logic [7:0] b;
    int r;
    punct_set  = ";{}#*<>/";
    letter_set = "etaoins";
    r = $urandom_range(0, 99);
    if (r < high_w) return 8'h80 | 8'($urandom_range(0, 127));
    if (r < high_w + punct_w) return punct_set[$urandom_range(0, 7)];
    if (r < high_w + punct_w + letter_w) begin
      b = letter_set[$urandom_range(0, 6)];
      if ($urandom_range(0, 1)) b = b - 8'h20;
      return b;
    end
    if (r > 97) return 8'h00;
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // one file: start, content, end; a tenth of the calls make stray or broken traffic
  task automatic queue_file(bit force_long);
    int len;
    int hdr_style;
    int sym_style;
    int punct_w;
    int letter_w;
    int high_w;
    bit split;
    logic [7:0] b;
    if (!force_long && $urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 3))
        0: queue_request(MODE_IGNORED, 2'($urandom), 1'($urandom), 8'($urandom));
        1: queue_request(fts_pkg::MODE_END, 2'($urandom), 1'($urandom), 8'($urandom));
        2: repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
        default: begin
          queue_request(fts_pkg::MODE_START, 2'($urandom), 1'($urandom), 8'($urandom));
          queue_request(fts_pkg::MODE_END, 2'($urandom), 1'($urandom), 8'($urandom));
        end
      endcase
      return;
    end
    if (force_long) len = $urandom_range(BLOCK_LEN - 4, BLOCK_LEN + 40);
    else if ($urandom_range(0, 99) < 15) len = $urandom_range(0, 5);
    else len = $urandom_range(6, 60);
    hdr_style = $urandom_range(0, 3);
    sym_style = $urandom_range(0, 2);
    split     = $urandom_range(0, 1);
    high_w    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    punct_w   = $urandom_range(0, 8);
    letter_w  = $urandom_range(0, 70);
    queue_request(fts_pkg::MODE_START,
                  ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3))
                                              : fts_pkg::KIND_REGULAR,
                  ($urandom_range(0, 3) == 0), 8'($urandom));
    for (int pos = 0; pos < len; pos++) begin
      b = text_byte(punct_w, letter_w, high_w);
      if (pos < 2 && hdr_style == 0) b = cfg_shadow.archive_magic[8*pos +: 8];
      if (pos < 2 && hdr_style == 1) b = cfg_shadow.exec_magic[8*pos +: 8];
      if (pos >= 2 && pos < 4 && hdr_style == 1 && split)
        b = cfg_shadow.split_marker[8*(pos-2) +: 8];
      if (pos >= 28 && pos <= 31) begin
        if (sym_style == 0) b = 8'h00;
        else if (sym_style == 1) b = (pos == 31) ? 8'($urandom_range(1, 255)) : 8'h00;
      end
      queue_byte(b);
    end
    queue_request(fts_pkg::MODE_END, 2'($urandom), 1'($urandom), 8'($urandom));
    if ($urandom_range(0, 9) == 0)
      queue_request(fts_pkg::MODE_END, 2'($urandom), 1'($urandom), 8'h00);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || classes_due.size() != 0);
    // trailing byte requests may still sit in the input register
    repeat (4) @(negedge clk);
  endtask

  initial begin
    cfg_shadow.archive_magic     = fts_pkg::ARCHIVE_MAGIC_RST;
    cfg_shadow.exec_magic        = fts_pkg::EXEC_MAGIC_RST;
    cfg_shadow.split_marker      = fts_pkg::SPLIT_MARKER_RST;
    cfg_shadow.code_pct_limit    = fts_pkg::CODE_PCT_RST;
    cfg_shadow.english_pct_limit = fts_pkg::ENGLISH_PCT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: end before any start, ignored mode, each special kind, repeated end
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(MODE_IGNORED, 2'b11, 1'b1, 8'hff);
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_DIR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_CHAR, 1'b1, 8'h00);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_BLOCK, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    // split executable with a short header
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_byte(fts_pkg::EXEC_MAGIC_RST[7:0]);
    queue_byte(fts_pkg::EXEC_MAGIC_RST[15:8]);
    queue_byte(fts_pkg::SPLIT_MARKER_RST[7:0]);
    queue_byte(fts_pkg::SPLIT_MARKER_RST[15:8]);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    // archive
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_REGULAR, 1'b1, 8'h00);
    queue_byte(fts_pkg::ARCHIVE_MAGIC_RST[7:0]);
    queue_byte(fts_pkg::ARCHIVE_MAGIC_RST[15:8]);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    // script, data, C, empty
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_REGULAR, 1'b1, 8'h00);
    queue_byte("a");
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_byte(8'h80);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_byte("{");
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_START, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    queue_request(fts_pkg::MODE_END, fts_pkg::KIND_REGULAR, 1'b0, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(fts_pkg::REG_ARCHIVE_MAGIC, 32'h0000);
          write_reg(fts_pkg::REG_EXEC_MAGIC, 32'hffff);
          write_reg(fts_pkg::REG_SPLIT_MARKER, 32'h0000);
          write_reg(fts_pkg::REG_CODE_PCT, 32'd0);
          write_reg(fts_pkg::REG_ENGLISH_PCT, 32'd0);
        end
        1: begin
          write_reg(fts_pkg::REG_ARCHIVE_MAGIC, 32'hffff);
          write_reg(fts_pkg::REG_EXEC_MAGIC, 32'h0000);
          write_reg(fts_pkg::REG_SPLIT_MARKER, 32'hffff);
          write_reg(fts_pkg::REG_CODE_PCT, 32'd100);
          write_reg(fts_pkg::REG_ENGLISH_PCT, 32'd100);
        end
        2: begin
          write_reg(fts_pkg::REG_ARCHIVE_MAGIC, 32'($urandom_range(0, 65535)));
          // sometimes both magics alike, archive has priority
          write_reg(fts_pkg::REG_EXEC_MAGIC,
                    $urandom_range(0, 1) ? 32'(cfg_shadow.archive_magic)
                                         : 32'($urandom_range(0, 65535)));
          write_reg(fts_pkg::REG_SPLIT_MARKER, 32'($urandom_range(0, 65535)));
          write_reg(fts_pkg::REG_CODE_PCT, 32'($urandom_range(0, 100)));
          write_reg(fts_pkg::REG_ENGLISH_PCT, 32'($urandom_range(0, 100)));
        end
        default: begin
          write_reg(fts_pkg::REG_ARCHIVE_MAGIC, 32'(fts_pkg::ARCHIVE_MAGIC_RST));
          write_reg(fts_pkg::REG_EXEC_MAGIC, 32'(fts_pkg::EXEC_MAGIC_RST));
          write_reg(fts_pkg::REG_SPLIT_MARKER, 32'(fts_pkg::SPLIT_MARKER_RST));
          write_reg(fts_pkg::REG_CODE_PCT, 32'($urandom_range(0, 10)));
          write_reg(fts_pkg::REG_ENGLISH_PCT, 32'($urandom_range(10, 50)));
        end
      endcase
      phase_items = 0;
      queue_file(ph == 0);
      while (phase_items < PHASE_REQUESTS) queue_file(1'b0);
      wait_drained();
    end

    repeat (12) @(negedge clk);
    if (fail_count == 0) begin
      $display("file_type_sniffer: match");
    end else begin
      $display("file_type_sniffer: mismatch");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("file_type_sniffer: mismatch");
    $finish;
  end

endmodule
